// ===== hdl/sdr_pkg.sv =====
`default_nettype none
package sdr_pkg;
  localparam int unsigned LOG2_BLOCK_BYTES = 9;
  localparam int unsigned POWER_UP_BYTES = 32;
  localparam int unsigned READY_BYTES = 10;

  typedef enum logic [2:0] {
    OP_BYTE  = 3'd0,
    OP_INIT  = 3'd1,
    OP_READ1 = 3'd2,
    OP_READN = 3'd3,
    OP_END   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    RC_OK       = 2'd0,
    RC_NOT_IDLE = 2'd1,
    RC_TIMEOUT  = 2'd2,
    RC_READ_ERR = 2'd3
  } rc_e;

  localparam logic [1:0] REG_FAST_CLOCK  = 2'd0;
  localparam logic [1:0] REG_POLL_LIMIT  = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT = 2'd2;

  localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
  localparam logic [5:0] CMD_OP_COND  = 6'd1;
  localparam logic [5:0] CMD_STOP     = 6'd12;
  localparam logic [5:0] CMD_READ1    = 6'd17;
  localparam logic [5:0] CMD_READN    = 6'd18;
  localparam logic [5:0] CMD_APP_OP   = 6'd41;
  localparam logic [5:0] CMD_APP      = 6'd55;

  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] BYTE_TOKEN = 8'hFE;
  localparam logic [7:0] BYTE_CRC   = 8'h95;
  localparam logic [7:0] BYTE_CMD   = 8'h40;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_READY   = 8'h00;
endpackage
`default_nettype wire

// ===== hdl/sd_spi_block_reader.sv =====
// Channel    Dir  Fields (lowest bit first)
// s_axis     in   tuser: op[2:0]; tdata: lba[22:0], card_byte[30:23]
// m_axis     out  tdata: send_valid, send_byte, card_select, spi_fast, data_valid,
//                 data_byte, done_res, result_code, busy_res; tlast: block_last
// cfg        in   0 fast_clock, 1 poll_limit, 2 retry_limit
// Each transfer is decided combinationally and its result sits in the output register.
// A new input transfer is taken every cycle while the output register is empty or drained.
// Reset returns the sequencer to idle with default limits.
`default_nettype none
module sd_spi_block_reader import sdr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // lba, card_byte
  input  wire logic [2:0]  s_axis_tuser,   // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // send_valid, send_byte, card_select, spi_fast, data_valid, data_byte, done_res,
  // result_code, busy_res
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  typedef enum logic [3:0] {
    PH_IDLE, PH_ZERO, PH_READY, PH_FRAME, PH_POLL, PH_TAIL_OK, PH_TAIL_NOT_IDLE,
    PH_TAIL_TIMEOUT, PH_TAIL_READ_ERR, PH_TOKEN, PH_DATA, PH_CRC, PH_HOLD
  } phase_e;

  phase_e phase_q, ph;
  logic [5:0]  step_q, st;
  logic [LOG2_BLOCK_BYTES-1:0] off_q, off;
  logic [15:0] poll_q, pc, retry_q, rc;
  logic        multi_q, mb, end_q, en;
  logic [22:0] addr_q, ad;
  logic [5:0]  cmd_q, cm;
  logic        fast_q;
  logic [15:0] plim_q, rlim_q;
  logic        out_v_q;
  logic [23:0] out_q;
  logic        out_last_q;

  logic [2:0] op;
  logic [22:0] lba;
  logic [7:0] b;
  logic ev_done, ev_dv, ev_last;
  logic [1:0] ev_code;
  logic [7:0] ev_db;
  logic [15:0] plim, rlim;
  logic sv, sel, fast, busy;
  logic [7:0] sb;
  logic [31:0] p;
  logic take;

  assign op = s_axis_tuser;
  assign lba = s_axis_tdata[22:0];
  assign b = s_axis_tdata[30:23];
  assign plim = (plim_q == 16'd0) ? 16'd1 : plim_q;
  assign rlim = (rlim_q == 16'd0) ? 16'd1 : rlim_q;
  assign s_axis_tready = !out_v_q || m_axis_tready;
  assign take = s_axis_tvalid && s_axis_tready;

  always_comb begin
    logic reply;
    logic [7:0] r;
    logic spent;
    ph = phase_q; st = step_q; off = off_q; pc = poll_q; rc = retry_q;
    mb = multi_q; en = end_q; ad = addr_q; cm = cmd_q;
    ev_done = 1'b0; ev_code = RC_OK; ev_dv = 1'b0; ev_db = 8'd0; ev_last = 1'b0;
    reply = 1'b0; r = b;
    spent = (retry_q + 16'd1) >= rlim;
    if (op == OP_BYTE) begin
      unique case (phase_q)
        PH_ZERO: begin
          st = step_q + 6'd1;
          if (st >= 6'(POWER_UP_BYTES)) begin ph = PH_READY; st = '0; end
        end
        PH_READY: begin
          st = step_q + 6'd1;
          if (st >= 6'(READY_BYTES)) begin ph = PH_FRAME; st = '0; cm = CMD_GO_IDLE; end
        end
        PH_FRAME: begin
          st = step_q + 6'd1;
          if (st >= 6'd8) begin ph = PH_POLL; pc = '0; end
        end
        PH_POLL: begin
          if (b != BYTE_IDLE) reply = 1'b1;
          else begin
            pc = poll_q + 16'd1;
            if (pc >= plim) begin reply = 1'b1; r = BYTE_IDLE; end
          end
        end
        PH_TAIL_OK, PH_TAIL_NOT_IDLE, PH_TAIL_TIMEOUT, PH_TAIL_READ_ERR: begin
          st = step_q + 6'd1;
          if (st >= 6'd2) begin
            ev_done = 1'b1;
            ev_code = 2'(phase_q - PH_TAIL_OK);
            ph = PH_IDLE; st = '0; en = 1'b0; mb = 1'b0;
          end
        end
        PH_TOKEN: begin
          if (b == BYTE_TOKEN) begin ph = PH_DATA; off = '0; end
          else begin
            pc = poll_q + 16'd1;
            if (pc >= plim) begin ph = PH_DATA; off = '0; end
          end
        end
        PH_DATA: begin
          off = off_q + 1'b1;
          if (!end_q) begin ev_dv = 1'b1; ev_db = b; ev_last = (off == '0); end
          if (off == '0) begin ph = PH_CRC; st = '0; end
        end
        PH_CRC: begin
          st = step_q + 6'd1;
          if (st >= 6'd2) begin
            if (end_q) begin
              if (multi_q) begin
                rc = '0; en = 1'b0; cm = CMD_STOP; ph = PH_FRAME; st = '0;
              end else begin
                ph = PH_IDLE; st = '0; en = 1'b0; mb = 1'b0; ev_done = 1'b1;
              end
            end else if (multi_q) begin ph = PH_TOKEN; pc = '0; end
            else ph = PH_HOLD;
          end
        end
        default: ;
      endcase
      if (reply) begin
        unique case (cmd_q)
          CMD_GO_IDLE: begin
            if (r == R1_IDLE) begin cm = CMD_APP; ph = PH_FRAME; st = '0; end
            else begin ph = PH_TAIL_NOT_IDLE; st = '0; end
          end
          CMD_APP: begin cm = CMD_APP_OP; ph = PH_FRAME; st = '0; end
          CMD_READ1, CMD_READN: begin
            if (r == R1_READY) begin
              mb = (cmd_q == CMD_READN); ph = PH_TOKEN; pc = '0; off = '0;
              ev_done = 1'b1;
            end else begin
              rc = retry_q + 16'd1;
              if (spent) begin ph = PH_TAIL_READ_ERR; st = '0; end
              else begin ph = PH_FRAME; st = '0; end
            end
          end
          CMD_STOP: begin
            if (r != R1_READY) rc = retry_q + 16'd1;
            if (r == R1_READY || spent) begin
              ph = PH_IDLE; st = '0; en = 1'b0; mb = 1'b0; ev_done = 1'b1;
            end else begin ph = PH_FRAME; st = '0; end
          end
          default: begin
            if (r == R1_READY) begin ph = PH_TAIL_OK; st = '0; end
            else begin
              rc = retry_q + 16'd1;
              if (spent) begin ph = PH_TAIL_TIMEOUT; st = '0; end
              else begin cm = CMD_OP_COND; ph = PH_FRAME; st = '0; end
            end
          end
        endcase
      end
    end else if (op == OP_INIT || op == OP_READ1 || op == OP_READN) begin
      if (phase_q == PH_IDLE) begin
        rc = '0; en = 1'b0; mb = 1'b0; st = '0;
        if (op == OP_INIT) ph = PH_ZERO;
        else begin
          ad = lba; ph = PH_FRAME;
          cm = (op == OP_READ1) ? CMD_READ1 : CMD_READN;
        end
      end
    end else if (op == OP_END) begin
      if (phase_q == PH_IDLE) ev_done = 1'b1;
      else if (phase_q == PH_HOLD || phase_q == PH_TOKEN) begin
        if (multi_q) begin
          rc = '0; en = 1'b0; cm = CMD_STOP; ph = PH_FRAME; st = '0;
        end else begin
          ph = PH_IDLE; st = '0; en = 1'b0; mb = 1'b0; ev_done = 1'b1;
        end
      end else if ((phase_q == PH_DATA || phase_q == PH_CRC) && !end_q) en = 1'b1;
    end
  end

  always_comb begin
    p = '0;
    if (cm == CMD_READ1 || cm == CMD_READN) p = 32'({ad, {LOG2_BLOCK_BYTES{1'b0}}});
    sv = (ph != PH_IDLE) && (ph != PH_HOLD);
    sb = BYTE_IDLE;
    if (!sv) sb = 8'd0;
    else if (ph == PH_ZERO) sb = 8'd0;
    else if (ph == PH_FRAME) begin
      unique case (st)
        6'd0: sb = BYTE_IDLE;
        6'd1: sb = BYTE_CMD | {2'b00, cm};
        6'd2: sb = p[31:24];
        6'd3: sb = p[23:16];
        6'd4: sb = p[15:8];
        6'd5: sb = p[7:0];
        6'd6: sb = BYTE_CRC;
        default: sb = BYTE_IDLE;
      endcase
    end
    sel = (ph != PH_IDLE) && (ph != PH_ZERO) && (ph != PH_READY);
    fast = fast_q && !(ph == PH_ZERO || ph == PH_READY || ph == PH_TAIL_OK ||
      ph == PH_TAIL_NOT_IDLE || ph == PH_TAIL_TIMEOUT ||
      ((ph == PH_FRAME || ph == PH_POLL) && (cm == CMD_GO_IDLE || cm == CMD_APP ||
      cm == CMD_APP_OP || cm == CMD_OP_COND)));
    busy = (ph != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; step_q <= '0; off_q <= '0; poll_q <= '0; retry_q <= '0;
      multi_q <= 1'b0; end_q <= 1'b0; addr_q <= '0; cmd_q <= '0;
      fast_q <= 1'b0; plim_q <= 16'hFFFF; rlim_q <= 16'hFFFF; out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FAST_CLOCK:  fast_q <= cfg_data_i[0];
          REG_POLL_LIMIT:  plim_q <= cfg_data_i;
          REG_RETRY_LIMIT: rlim_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (take) begin
        phase_q <= ph; step_q <= st; off_q <= off; poll_q <= pc; retry_q <= rc;
        multi_q <= mb; end_q <= en; addr_q <= ad; cmd_q <= cm;
        out_v_q <= 1'b1;
      end else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= {busy, ev_code, ev_done, ev_db, ev_dv, fast, sel, sb, sv};
      out_last_q <= ev_last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;
  assign m_axis_tlast = out_last_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tlast))
    else $error("result lost under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("input blocked while output empty");
  a_idle_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> end_q == 1'b0) else $error("end flag left set in idle");
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import sdr_pkg::*;

  class reply_scoreboard;
    logic [24:0] pending_q[$];
    int errors = 0;
    string names[10] = '{"send_valid", "send_byte", "card_select", "spi_fast", "data_valid",
                         "data_byte", "block_last", "done_res", "result_code", "busy_res"};
    int lsb[10] = '{0, 1, 9, 10, 11, 12, 20, 21, 22, 24};
    int wid[10] = '{1, 8, 1, 1, 1, 8, 1, 1, 2, 1};

    function void note_input(logic [24:0] e);
      pending_q.push_back(e);
    endfunction

    function void check_reply(logic [24:0] a);
      logic [24:0] e;
      logic [24:0] m;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %h", $time, a);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      for (int i = 0; i < 10; i++) begin
        m = ((25'd1 << wid[i]) - 25'd1) << lsb[i];
        if ((e & m) != (a & m)) begin
          $display("%0t: %s expected %0h actual %0h", $time, names[i],
                   (e & m) >> lsb[i], (a & m) >> lsb[i]);
          errors++;
        end
      end
    endfunction
  endclass

  typedef enum logic [3:0] {
    PH_IDLE, PH_ZERO, PH_READY, PH_FRAME, PH_POLL, PH_TAIL_OK, PH_TAIL_NOT_IDLE,
    PH_TAIL_TIMEOUT, PH_TAIL_READ_ERR, PH_TOKEN, PH_DATA, PH_CRC, PH_HOLD
  } seq_phase_e;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [15:0] cfg_data_i;

  sd_spi_block_reader u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  reply_scoreboard sb = new();

  seq_phase_e ph;
  logic [5:0] step_cnt, cur_cmd;
  logic [8:0] blk_off;
  logic [15:0] poll_cnt, retry_cnt, poll_lim, retry_lim;
  logic multi, ending, fast_clk;
  logic [22:0] blk_addr;
  logic ev_done, ev_dv, ev_last;
  logic [1:0] ev_code;
  logic [7:0] ev_db;

  bit quiet = 0;
  int accepted = 0;
  int idle_cycles = 0;

  function void start_cmd(logic [5:0] c);
    cur_cmd = c;
    ph = PH_FRAME;
    step_cnt = 0;
  endfunction

  function void finish_op(logic [1:0] code);
    ph = PH_IDLE;
    step_cnt = 0;
    ending = 0;
    multi = 0;
    ev_done = 1;
    ev_code = code;
  endfunction

  function void finish_read();
    if (multi) begin
      retry_cnt = 0;
      ending = 0;
      start_cmd(CMD_STOP);
    end else begin
      finish_op(RC_OK);
    end
  endfunction

  function bit retries_spent();
    logic [15:0] lim;
    lim = (retry_lim == 0) ? 16'd1 : retry_lim;
    retry_cnt++;
    return retry_cnt >= lim;
  endfunction

  function void enter_tail(seq_phase_e p);
    ph = p;
    step_cnt = 0;
  endfunction

  function void handle_reply(logic [7:0] r);
    case (cur_cmd)
      CMD_GO_IDLE: begin
        if (r == R1_IDLE) start_cmd(CMD_APP);
        else enter_tail(PH_TAIL_NOT_IDLE);
      end
      CMD_APP: start_cmd(CMD_APP_OP);
      CMD_READ1, CMD_READN: begin
        if (r == R1_READY) begin
          multi = (cur_cmd == CMD_READN);
          ph = PH_TOKEN;
          poll_cnt = 0;
          blk_off = 0;
          ev_done = 1;
          ev_code = RC_OK;
        end else if (retries_spent()) begin
          enter_tail(PH_TAIL_READ_ERR);
        end else begin
          start_cmd(cur_cmd);
        end
      end
      CMD_STOP: begin
        if (r == R1_READY || retries_spent()) finish_op(RC_OK);
        else start_cmd(CMD_STOP);
      end
      default: begin
        if (r == R1_READY) enter_tail(PH_TAIL_OK);
        else if (retries_spent()) enter_tail(PH_TAIL_TIMEOUT);
        else start_cmd(CMD_OP_COND);
      end
    endcase
  endfunction

  function void take_card_byte(logic [7:0] b);
    logic [15:0] plim;
    plim = (poll_lim == 0) ? 16'd1 : poll_lim;
    case (ph)
      PH_ZERO: begin
        step_cnt++;
        if (step_cnt >= POWER_UP_BYTES) begin
          ph = PH_READY;
          step_cnt = 0;
        end
      end
      PH_READY: begin
        step_cnt++;
        if (step_cnt >= READY_BYTES) start_cmd(CMD_GO_IDLE);
      end
      PH_FRAME: begin
        step_cnt++;
        if (step_cnt >= 8) begin
          ph = PH_POLL;
          poll_cnt = 0;
        end
      end
      PH_POLL: begin
        if (b != BYTE_IDLE) begin
          handle_reply(b);
        end else begin
          poll_cnt++;
          if (poll_cnt >= plim) handle_reply(BYTE_IDLE);
        end
      end
      PH_TAIL_OK, PH_TAIL_NOT_IDLE, PH_TAIL_TIMEOUT, PH_TAIL_READ_ERR: begin
        step_cnt++;
        if (step_cnt >= 2) finish_op(2'(ph - PH_TAIL_OK));
      end
      PH_TOKEN: begin
        if (b == BYTE_TOKEN) begin
          ph = PH_DATA;
          blk_off = 0;
        end else begin
          poll_cnt++;
          if (poll_cnt >= plim) begin
            ph = PH_DATA;
            blk_off = 0;
          end
        end
      end
      PH_DATA: begin
        blk_off = blk_off + 9'd1;
        if (!ending) begin
          ev_dv = 1;
          ev_db = b;
          ev_last = (blk_off == 0);
        end
        if (blk_off == 0) begin
          ph = PH_CRC;
          step_cnt = 0;
        end
      end
      PH_CRC: begin
        step_cnt++;
        if (step_cnt >= 2) begin
          if (ending) finish_read();
          else if (multi) begin
            ph = PH_TOKEN;
            poll_cnt = 0;
          end else ph = PH_HOLD;
        end
      end
      default: ;
    endcase
  endfunction

  function logic [7:0] frame_byte();
    logic [31:0] p;
    p = 0;
    if (cur_cmd == CMD_READ1 || cur_cmd == CMD_READN) p = {blk_addr, 9'd0};
    case (step_cnt)
      0: return BYTE_IDLE;
      1: return BYTE_CMD | {2'b00, cur_cmd};
      2: return p[31:24];
      3: return p[23:16];
      4: return p[15:8];
      5: return p[7:0];
      6: return BYTE_CRC;
      default: return BYTE_IDLE;
    endcase
  endfunction

  function bit in_init();
    if (ph inside {PH_ZERO, PH_READY, PH_TAIL_OK, PH_TAIL_NOT_IDLE, PH_TAIL_TIMEOUT})
      return 1;
    if (ph == PH_FRAME || ph == PH_POLL)
      return cur_cmd inside {CMD_GO_IDLE, CMD_APP, CMD_APP_OP, CMD_OP_COND};
    return 0;
  endfunction

  function logic [24:0] predict_reply(logic [2:0] op, logic [22:0] lba, logic [7:0] b);
    logic sv;
    logic [7:0] sbyte;
    ev_done = 0; ev_code = 0; ev_dv = 0; ev_db = 0; ev_last = 0;
    if (op == OP_BYTE) begin
      take_card_byte(b);
    end else if (op == OP_INIT || op == OP_READ1 || op == OP_READN) begin
      if (ph == PH_IDLE) begin
        retry_cnt = 0;
        ending = 0;
        multi = 0;
        if (op == OP_INIT) begin
          ph = PH_ZERO;
          step_cnt = 0;
        end else begin
          blk_addr = lba;
          start_cmd(op == OP_READ1 ? CMD_READ1 : CMD_READN);
        end
      end
    end else if (op == OP_END) begin
      if (ph == PH_IDLE) finish_op(RC_OK);
      else if (ph == PH_HOLD || ph == PH_TOKEN) finish_read();
      else if ((ph == PH_DATA || ph == PH_CRC) && !ending) ending = 1;
    end
    sv = (ph != PH_IDLE && ph != PH_HOLD);
    if (!sv) sbyte = 0;
    else if (ph == PH_ZERO) sbyte = 8'h00;
    else if (ph == PH_FRAME) sbyte = frame_byte();
    else sbyte = BYTE_IDLE;
    return {ph != PH_IDLE, ev_code, ev_done, ev_last, ev_db, ev_dv, fast_clk && !in_init(),
            ph != PH_IDLE && ph != PH_ZERO && ph != PH_READY, sbyte, sv};
  endfunction

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_item(logic [2:0] op, logic [22:0] lba, logic [7:0] b);
    s_axis_tdata <= {1'b0, b, lba};
    s_axis_tuser <= op;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(predict_reply(op, lba, b));
    accepted++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    cfg_we_i <= 1;
    @(posedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      REG_FAST_CLOCK:  fast_clk = val[0];
      REG_POLL_LIMIT:  poll_lim = val;
      REG_RETRY_LIMIT: retry_lim = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic fast, logic [15:0] plim, logic [15:0] rlim);
    s_axis_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    write_reg(REG_FAST_CLOCK, {15'd0, fast});
    write_reg(REG_POLL_LIMIT, plim);
    write_reg(REG_RETRY_LIMIT, rlim);
  endtask

  function logic [7:0] card_reply();
    int r;
    r = $urandom_range(0, 15);
    if (ph == PH_POLL) begin
      if (r < 2) return BYTE_IDLE;
      if (r == 2) return 8'($urandom);
      if (r == 3) return R1_IDLE;
      return (cur_cmd == CMD_GO_IDLE) ? R1_IDLE : R1_READY;
    end
    if (ph == PH_TOKEN) return (r < 3) ? BYTE_IDLE : BYTE_TOKEN;
    return 8'($urandom);
  endfunction

  task automatic random_items(int n);
    int r;
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 999);
      if (ph == PH_IDLE) begin
        if (r < 200) op = OP_INIT;
        else if (r < 500) op = OP_READ1;
        else if (r < 800) op = OP_READN;
        else if (r < 880) op = OP_END;
        else op = 3'($urandom_range(5, 7));
      end else if (ph == PH_HOLD) begin
        op = (r < 800) ? OP_END : OP_BYTE;
      end else begin
        if (r < 975) op = OP_BYTE;
        else if (r < 990) op = OP_END;
        else op = 3'($urandom_range(1, 7));
      end
      send_item(op, 23'($urandom), card_reply());
    end
  endtask

  initial begin
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tuser = 0;
    m_axis_tready = 0;
    cfg_we_i = 0;
    cfg_idx_i = 0;
    cfg_data_i = 0;
    ph = PH_IDLE; step_cnt = 0; cur_cmd = 0; blk_off = 0; poll_cnt = 0; retry_cnt = 0;
    multi = 0; ending = 0; blk_addr = 0; fast_clk = 0; poll_lim = 16'hFFFF;
    retry_lim = 16'hFFFF;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_item(OP_END, 23'd0, 8'h00);
    send_item(3'd5, 23'h7FFFFF, 8'hFF);
    send_item(3'd6, 23'd0, 8'h00);
    send_item(3'd7, 23'd0, 8'h00);
    send_item(OP_BYTE, 23'd0, 8'hFF);
    send_item(OP_READN, 23'h7FFFFF, 8'h00);
    send_item(OP_READ1, 23'd0, 8'h00);
    send_item(OP_INIT, 23'd0, 8'h00);
    send_item(OP_END, 23'd0, 8'h00);
    random_items(300);

    set_limits(1'b1, 16'd3, 16'd2);
    random_items(300);
    set_limits(1'b0, 16'd1, 16'd1);
    random_items(300);
    set_limits(1'b1, 16'hFFFF, 16'hFFFF);
    random_items(300);
    set_limits(1'b1, 16'd8, 16'd5);
    random_items(200);
    quiet = 1;
    random_items(150);

    s_axis_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    bit held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && accepted >= 200) begin
        held = 1;
        m_axis_tready <= 0;
        repeat (300) @(posedge clk_i);
        m_axis_tready <= 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        m_axis_tready <= 1;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_reply({m_axis_tdata[23:20], m_axis_tlast, m_axis_tdata[19:0]});
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("Mismatches found");
      $finish;
    end
  end
endmodule
